/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/dremenc_pkg.sv */
// Types and constants of the data rate exponent/mantissa encoder.
package dremenc_pkg;

    localparam int unsigned IN_W       = 32;
    localparam int unsigned BAUD_W     = 19;
    localparam int unsigned FX_W       = 25;
    localparam int unsigned EXP_W      = 4;
    localparam int unsigned EXP_CNT    = 16;
    localparam int unsigned MANT_W     = 8;
    localparam int unsigned ACH_W      = 21;

    localparam logic [IN_W-1:0]   BAUD_MIN      = 32'd600;
    localparam logic [IN_W-1:0]   BAUD_MAX      = 32'd500000;
    localparam logic [EXP_W-1:0]  EXP_MAX       = 4'd15;
    localparam logic [MANT_W-1:0] MANT_MAX      = 8'd255;
    localparam logic [FX_W-1:0]   CRYSTAL_RESET = 25'd26000000;

    // exponent search compares crystal * 2^k against baud * 2^20
    localparam int unsigned BAUD_SHIFT = 20;
    localparam int unsigned CMP_W      = FX_W + EXP_CNT - 1;

    // rounded quotient floor((baud*2^29 + d) / (2d)), d = crystal * 2^E
    localparam int unsigned NUM_SHIFT  = 29;
    localparam int unsigned Q_W        = MANT_W + 2;
    localparam int unsigned DIV_W      = FX_W + EXP_CNT;
    localparam int unsigned REM_W      = DIV_W + Q_W - 1;

    // achieved rate = ((256 + M) * crystal) << E >> 28
    localparam int unsigned PROD_W     = MANT_W + 1 + FX_W;
    localparam int unsigned SH_W       = PROD_W + EXP_CNT - 1;
    localparam int unsigned FRAC_SHIFT = 28;

    typedef struct packed {
        logic              valid;
        logic [EXP_W-1:0]  expo;
        logic [FX_W-1:0]   fx;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIV_W-1:0]  dvsr;
        logic [Q_W-1:0]    quo;
    } t_div;

endpackage

/* rtl/data_rate_exponent_mantissa_encoder_top.sv */
// Top level of the data rate exponent/mantissa encoder.
// Encodes a requested symbol rate into exponent E and mantissa M of a rate
// (256+M) * 2^E * crystal / 2^28, and reports the rate E and M really give.
// A request is taken at every rising edge with start high; busy is always low,
// so one request per cycle goes in. Each result passes through Q_W + 6
// stages (input register, exponent search, divider setup, ten division cells,
// mantissa fix, multiply, output register) and appears on the result
// ports for one cycle with o_strobe high; the receiver cannot stall it, so
// take it then. The request is clamped to 600..500000 baud. The crystal value
// is sampled when a request is taken and travels with it; write the crystal
// register only while no request is in flight.
`include "assert_macros.svh"

module data_rate_exponent_mantissa_encoder_top import dremenc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [FX_W-1:0]   i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [IN_W-1:0]   i_requested_baud,
    output logic              o_strobe,
    output logic [EXP_W-1:0]  o_rate_exponent,
    output logic [MANT_W-1:0] o_rate_mantissa,
    output logic [ACH_W-1:0]  o_achieved_baud
);

    localparam int unsigned LATENCY = Q_W + 6;

    // crystal register
    logic [FX_W-1:0]   r_crystal_hz;

    // input stage
    logic [BAUD_W-1:0] n_in_baud;
    logic              r_in_valid;
    logic [BAUD_W-1:0] r_in_baud;
    logic [FX_W-1:0]   r_in_fx;

    // exponent search output
    t_side             w_exp_side;
    logic [BAUD_W-1:0] w_exp_baud;

    // divider setup
    logic [DIV_W-1:0]  w_d;
    t_div              n_prep_div;
    logic              r_prep_valid;
    t_side             r_prep_side;
    t_div              r_prep_div;

    // division chain
    t_side             w_side [0:Q_W];
    t_div              w_div  [0:Q_W];

    // mantissa fix
    logic [EXP_W-1:0]  n_fix_expo;
    logic [MANT_W-1:0] n_fix_mant;
    logic              r_fix_valid;
    logic [EXP_W-1:0]  r_fix_expo;
    logic [MANT_W-1:0] r_fix_mant;
    logic [FX_W-1:0]   r_fix_fx;

    // multiply
    logic              r_mul_valid;
    logic [EXP_W-1:0]  r_mul_expo;
    logic [MANT_W-1:0] r_mul_mant;
    logic [PROD_W-1:0] r_mul_prod;

    // output
    logic [SH_W-1:0]   w_scaled;
    logic              r_strobe;
    logic [EXP_W-1:0]  r_out_expo;
    logic [MANT_W-1:0] r_out_mant;
    logic [ACH_W-1:0]  r_out_ach;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crystal_hz <= CRYSTAL_RESET;
        end else if (i_cfg_we) begin
            r_crystal_hz <= i_cfg_wdata;
        end
    end

    // Clamp the request into the supported range before anything else.
    always_comb begin
        if (i_requested_baud < BAUD_MIN) begin
            n_in_baud = BAUD_W'(BAUD_MIN);
        end else if (i_requested_baud > BAUD_MAX) begin
            n_in_baud = BAUD_W'(BAUD_MAX);
        end else begin
            n_in_baud = i_requested_baud[BAUD_W-1:0];
        end
    end

    // Reset clears the valid bit of every stage; besides these, only the crystal register is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prep_valid <= 1'b0;
            r_fix_valid  <= 1'b0;
            r_mul_valid  <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_in_valid   <= start && !busy;
            r_prep_valid <= w_exp_side.valid;
            r_fix_valid  <= w_side[Q_W].valid;
            r_mul_valid  <= r_fix_valid;
            r_strobe     <= r_mul_valid;
        end
    end

    // Capture the clamped request with the crystal value it is encoded for.
    always_ff @(posedge i_clk) begin
        r_in_baud <= n_in_baud;
        r_in_fx   <= r_crystal_hz;
    end

    dremenc_exp_search u_exp_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_baud  (r_in_baud),
        .i_fx    (r_in_fx),
        .o_side  (w_exp_side),
        .o_baud  (w_exp_baud)
    );

    // Form numerator baud*2^29 + d and divisor 2d for round-half-up.
    assign w_d = DIV_W'(w_exp_side.fx) << w_exp_side.expo;

    always_comb begin
        n_prep_div.rem  = (REM_W'(w_exp_baud) << NUM_SHIFT) + REM_W'(w_d);
        n_prep_div.dvsr = w_d << 1;
        n_prep_div.quo  = '0;
    end

    always_ff @(posedge i_clk) begin
        r_prep_side <= w_exp_side;
        r_prep_div  <= n_prep_div;
    end

    always_comb begin
        w_side[0]       = r_prep_side;
        w_side[0].valid = r_prep_valid;
    end

    assign w_div[0] = r_prep_div;

    // Row of division cells, most significant quotient bit first. The top
    // bit only flags a quotient past 511; the bits below it are then unused.
    for (genvar gi = 0; gi < Q_W; gi++) begin : g_div
        dremenc_div_cell #(
            .SHIFT (Q_W - 1 - gi)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_side[gi]),
            .i_div   (w_div[gi]),
            .o_side  (w_side[gi+1]),
            .o_div   (w_div[gi+1])
        );
    end

    // Turn the rounded quotient into E and M: carry into E on overflow,
    // saturate M at the top exponent, clamp a quotient below 256 to zero.
    always_comb begin
        n_fix_expo = w_side[Q_W].expo;
        n_fix_mant = w_div[Q_W].quo[MANT_W-1:0];
        if (w_div[Q_W].quo[Q_W-1]) begin
            if (w_side[Q_W].expo != EXP_MAX) begin
                n_fix_expo = w_side[Q_W].expo + EXP_W'(1);
                n_fix_mant = '0;
            end else begin
                n_fix_mant = MANT_MAX;
            end
        end else if (!w_div[Q_W].quo[MANT_W]) begin
            n_fix_mant = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fix_expo <= n_fix_expo;
        r_fix_mant <= n_fix_mant;
        r_fix_fx   <= w_side[Q_W].fx;
    end

    // (256 + M) * crystal
    always_ff @(posedge i_clk) begin
        r_mul_prod <= PROD_W'({1'b1, r_fix_mant}) * PROD_W'(r_fix_fx);
        r_mul_expo <= r_fix_expo;
        r_mul_mant <= r_fix_mant;
    end

    // Scale by 2^E, drop 28 fraction bits, keep 21 bits.
    assign w_scaled = SH_W'(r_mul_prod) << r_mul_expo;

    always_ff @(posedge i_clk) begin
        r_out_expo <= r_mul_expo;
        r_out_mant <= r_mul_mant;
        r_out_ach  <= w_scaled[FRAC_SHIFT +: ACH_W];
    end

    assign o_strobe        = r_strobe;
    assign o_rate_exponent = r_out_expo;
    assign o_rate_mantissa = r_out_mant;
    assign o_achieved_baud = r_out_ach;

    // A result only leaves for a request that was taken with start high.
    `ASSERT_IMP(a_latency, i_clk, i_rst_n, o_strobe, $past(start, LATENCY))
    // E is maximal, so a quotient that does not overflow is at least 256.
    `ASSERT_IMP(a_quo_floor, i_clk, i_rst_n, w_side[Q_W].valid && !w_div[Q_W].quo[Q_W-1], w_div[Q_W].quo[MANT_W])
    // Below the top exponent the achieved rate cannot truncate to zero.
    `ASSERT_NXT(a_ach_nonzero, i_clk, i_rst_n, r_mul_valid && r_mul_expo != EXP_MAX, o_achieved_baud != '0)

endmodule

/* rtl/dremenc_exp_search.sv */
// Exponent search stage: largest E with crystal * 2^E <= baud * 2^20.
module dremenc_exp_search import dremenc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BAUD_W-1:0] i_baud,
    input  logic [FX_W-1:0]   i_fx,
    output t_side             o_side,
    output logic [BAUD_W-1:0] o_baud
);

    logic [EXP_W-1:0]  n_expo;
    logic [CMP_W-1:0]  w_limit;
    logic              r_valid;
    logic [EXP_W-1:0]  r_expo;
    logic [FX_W-1:0]   r_fx;
    logic [BAUD_W-1:0] r_baud;

    assign w_limit = CMP_W'(i_baud) << BAUD_SHIFT;

    // independent compares, highest passing exponent wins
    always_comb begin
        n_expo = '0;
        for (int k = 0; k < EXP_CNT; k++) begin
            if ((CMP_W'(i_fx) << k) <= w_limit) begin
                n_expo = EXP_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_expo <= n_expo;
        r_fx   <= i_fx;
        r_baud <= i_baud;
    end

    assign o_side = '{valid: r_valid, expo: r_expo, fx: r_fx};
    assign o_baud = r_baud;

endmodule

/* rtl/dremenc_div_cell.sv */
// One restoring-division cell: resolves one quotient bit and hands on.
module dremenc_div_cell import dremenc_pkg::*; #(
    parameter int unsigned SHIFT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_side i_side,
    input  t_div  i_div,
    output t_side o_side,
    output t_div  o_div
);

    logic [REM_W-1:0] w_trial;
    logic             w_ge;
    t_div             n_div;
    logic             r_valid;
    t_side            r_side;
    t_div             r_div;

    assign w_trial = REM_W'(i_div.dvsr) << SHIFT;
    assign w_ge    = i_div.rem >= w_trial;

    always_comb begin
        n_div = i_div;
        if (w_ge) begin
            n_div.rem = i_div.rem - w_trial;
        end
        n_div.quo[SHIFT] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_div  <= n_div;
    end

    always_comb begin
        o_side       = r_side;
        o_side.valid = r_valid;
    end

    assign o_div = r_div;

endmodule
